// ===== rtl/core/rjd_pkg.sv =====
// shared types and codes of the ready/blocked job dispatcher
// no dependencies; used by the queue cells, the queue and the top level
package rjd_pkg;

	typedef struct packed {
		logic [15:0] cpu;
		logic [7:0]  io;
		logic [15:0] process;
		logic [15:0] start;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	// push and pop control of one queue
	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_IRQ  = 2'd2;

	localparam logic [7:0] IRQ_UNBLOCK = 8'd0;
	localparam logic [7:0] IRQ_SWITCH  = 8'd1;

	typedef enum logic [3:0] {
		ST_SWITCHED      = 4'd0,
		ST_UNBLOCKED     = 4'd1,
		ST_BLOCKED_EMPTY = 4'd2,
		ST_UNIMPL        = 4'd3,
		ST_LOADED        = 4'd4,
		ST_NO_JOBS       = 4'd5,
		ST_ONLY_BLOCKED  = 4'd6,
		ST_TO_BLOCKED    = 4'd7,
		ST_FINISHED      = 4'd8,
		ST_DECREMENTED   = 4'd9,
		ST_ADDED         = 4'd10
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_UNBLOCK
	} fsm_t;

endpackage

// ===== rtl/core/rjd_if.sv =====
// valid/ready channel interfaces for dispatcher commands and results
// depends on nothing but the channel widths of the dispatcher
interface rjd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  interrupt_code;
	logic [15:0] job_cpu_time;
	logic [7:0]  job_io_time;
	logic [15:0] job_process;
	logic [15:0] job_start;

	modport source (
		output valid, op, interrupt_code, job_cpu_time, job_io_time, job_process, job_start,
		input  ready
	);
	modport sink (
		input  valid, op, interrupt_code, job_cpu_time, job_io_time, job_process, job_start,
		output ready
	);
endinterface

interface rjd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic        dropped;
	logic        run_valid;
	logic [15:0] run_cpu_time;
	logic [7:0]  run_io_time;
	logic [15:0] run_process;
	logic [15:0] run_start;

	modport source (
		output valid, status, dropped, run_valid, run_cpu_time, run_io_time, run_process,
		       run_start,
		input  ready
	);
	modport sink (
		input  valid, status, dropped, run_valid, run_cpu_time, run_io_time, run_process,
		       run_start,
		output ready
	);
endinterface

// ===== rtl/core/rjd_cell.sv =====
// one entry of a shifting job queue: holds a job and a valid bit
// depends on rjd_pkg; a row of these forms rjd_queue
module rjd_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  rjd_pkg::qctl_t ctl,
	input  rjd_pkg::job_t push_data,
	input  logic          prev_valid,
	input  logic          next_valid,
	input  rjd_pkg::job_t next_data,
	output logic          valid,
	output rjd_pkg::job_t data
);

	logic valid_q;
	rjd_pkg::job_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			// shift toward the head; the last valid cell takes a pushed job
			valid_q <= next_valid | (ctl.push & valid_q);
		end else if (ctl.push && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			if (next_valid) begin
				data_q <= next_data;
			end else if (ctl.push && valid_q) begin
				data_q <= push_data;
			end
		end else if (ctl.push && !valid_q && prev_valid) begin
			data_q <= push_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// ===== rtl/core/rjd_queue.sv =====
// job FIFO built as a chain of rjd_cell entries, head at cell 0
// depends on rjd_pkg and rjd_cell
module rjd_queue #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rjd_pkg::qctl_t ctl,
	input  rjd_pkg::job_t push_data,
	output rjd_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	logic [DEPTH-1:0] valid;
	rjd_pkg::job_t data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic          prev_v;
		logic          next_v;
		rjd_pkg::job_t next_d;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_inner
			assign next_v = valid[i+1];
			assign next_d = data[i+1];
		end

		rjd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.push_data (push_data),
			.prev_valid(prev_v),
			.next_valid(next_v),
			.next_data (next_d),
			.valid     (valid[i]),
			.data      (data[i])
		);
	end

	assign head  = data[0];
	assign empty = ~valid[0];
	assign full  = valid[DEPTH-1];

endmodule

// ===== rtl/core/ready_blocked_job_dispatcher.sv =====
// top level of the ready/blocked job dispatcher
// depends on rjd_pkg, rjd_if and rjd_queue

// Round-robin dispatcher with a ready queue, a blocked queue (each QUEUE_DEPTH
// jobs, built as shifting chains of cells) and one running job. Add, tick,
// switch and unknown commands are answered directly from the idle state. An
// unblock interrupt walks the blocked chain one job per cycle into the ready
// chain and gives its result once the blocked chain is empty. The result sits
// in an output register, so a new command is taken while the previous result
// is being handed over. No clearing pass follows reset.
module ready_blocked_job_dispatcher #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rjd_in_if.sink    job_in,
	rjd_out_if.source res_out
);

	rjd_pkg::fsm_t state_q, state_d;

	rjd_pkg::job_t   run_q, run_d;
	logic            run_valid_q, run_valid_d;
	logic            drop_acc_q, drop_acc_d;

	rjd_pkg::qctl_t  rdy_ctl, blk_ctl;
	rjd_pkg::job_t   rdy_push, blk_push;
	rjd_pkg::job_t   rdy_head, blk_head;
	logic            rdy_empty, rdy_full, blk_empty, blk_full;

	logic            res_load;
	rjd_pkg::status_t res_status;
	logic            res_dropped;

	logic            out_valid_q;
	logic [3:0]      out_status_q;
	logic            out_dropped_q;
	logic            out_run_valid_q;
	rjd_pkg::job_t   out_job_q;

	logic            in_fire;
	logic            is_unblock;
	rjd_pkg::job_t   new_job;
	logic [15:0]     cpu_dec;
	rjd_pkg::status_t idle_status;

	rjd_queue #(.DEPTH(QUEUE_DEPTH)) u_ready (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rdy_ctl),
		.push_data(rdy_push),
		.head     (rdy_head),
		.empty    (rdy_empty),
		.full     (rdy_full)
	);

	rjd_queue #(.DEPTH(QUEUE_DEPTH)) u_blocked (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (blk_ctl),
		.push_data(blk_push),
		.head     (blk_head),
		.empty    (blk_empty),
		.full     (blk_full)
	);

	assign job_in.ready = (state_q == rjd_pkg::FSM_IDLE) & (~out_valid_q | res_out.ready);
	assign in_fire      = job_in.valid & job_in.ready;
	assign is_unblock   = (job_in.op == rjd_pkg::OP_IRQ) &
	                      (job_in.interrupt_code == rjd_pkg::IRQ_UNBLOCK) & ~blk_empty;
	assign cpu_dec      = run_q.cpu - 16'd1;
	assign idle_status  = blk_empty ? rjd_pkg::ST_NO_JOBS : rjd_pkg::ST_ONLY_BLOCKED;

	always_comb begin
		new_job.cpu     = job_in.job_cpu_time;
		new_job.io      = job_in.job_io_time;
		new_job.process = job_in.job_process;
		new_job.start   = job_in.job_start;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rjd_pkg::FSM_IDLE: begin
				if (in_fire && is_unblock) state_d = rjd_pkg::FSM_UNBLOCK;
			end
			rjd_pkg::FSM_UNBLOCK: begin
				if (blk_empty) state_d = rjd_pkg::FSM_IDLE;
			end
			default: state_d = rjd_pkg::FSM_IDLE;
		endcase
	end

	// queue controls, running job update and result
	always_comb begin
		rdy_ctl     = '0;
		blk_ctl     = '0;
		rdy_push    = new_job;
		blk_push    = run_q;
		run_d       = run_q;
		run_valid_d = run_valid_q;
		drop_acc_d  = drop_acc_q;
		res_load    = 1'b0;
		res_status  = rjd_pkg::ST_UNIMPL;
		res_dropped = 1'b0;

		unique case (state_q)
			rjd_pkg::FSM_IDLE: begin
				if (in_fire) begin
					res_load = ~is_unblock;
					unique case (job_in.op)
						rjd_pkg::OP_ADD: begin
							rdy_ctl.push = 1'b1;
							res_dropped  = rdy_full;
							res_status   = rjd_pkg::ST_ADDED;
						end
						rjd_pkg::OP_TICK: begin
							if (run_valid_q && run_q.cpu != 16'd0) begin
								if (cpu_dec == 16'd0) begin
									if (run_q.io == 8'd1) begin
										blk_push     = '0;
										blk_push.process = run_q.process;
										blk_push.start   = run_q.start;
										blk_ctl.push = 1'b1;
										res_dropped  = blk_full;
										res_status   = rjd_pkg::ST_TO_BLOCKED;
									end else begin
										res_status = rjd_pkg::ST_FINISHED;
									end
									run_d       = '0;
									run_valid_d = 1'b0;
								end else begin
									run_d.cpu  = cpu_dec;
									res_status = rjd_pkg::ST_DECREMENTED;
								end
							end else if (!rdy_empty) begin
								rdy_ctl.pop = 1'b1;
								run_d       = rdy_head;
								run_valid_d = 1'b1;
								res_status  = rjd_pkg::ST_LOADED;
							end else begin
								res_status = idle_status;
							end
						end
						rjd_pkg::OP_IRQ: begin
							if (job_in.interrupt_code == rjd_pkg::IRQ_SWITCH) begin
								if (!rdy_empty) begin
									// pop and push in the same cycle, so the push always fits
									rdy_ctl.pop  = 1'b1;
									rdy_ctl.push = run_valid_q;
									rdy_push     = run_q;
									run_d        = rdy_head;
									run_valid_d  = 1'b1;
									res_status   = rjd_pkg::ST_SWITCHED;
								end else begin
									res_status = idle_status;
								end
							end else if (job_in.interrupt_code == rjd_pkg::IRQ_UNBLOCK) begin
								drop_acc_d = 1'b0;
								res_status = rjd_pkg::ST_BLOCKED_EMPTY;
							end else begin
								res_status = rjd_pkg::ST_UNIMPL;
							end
						end
						default: res_status = rjd_pkg::ST_UNIMPL;
					endcase
				end
			end
			rjd_pkg::FSM_UNBLOCK: begin
				if (blk_empty) begin
					res_load    = 1'b1;
					res_status  = rjd_pkg::ST_UNBLOCKED;
					res_dropped = drop_acc_q;
				end else begin
					blk_ctl.pop  = 1'b1;
					rdy_ctl.push = 1'b1;
					rdy_push     = blk_head;
					drop_acc_d   = drop_acc_q | rdy_full;
				end
			end
			default: begin
				res_status = rjd_pkg::ST_UNIMPL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rjd_pkg::FSM_IDLE;
			run_q       <= '0;
			run_valid_q <= 1'b0;
			drop_acc_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			run_q       <= run_d;
			run_valid_q <= run_valid_d;
			drop_acc_q  <= drop_acc_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// running job is kept zero while no job runs, so it goes out as is
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_status_q    <= res_status;
			out_dropped_q   <= res_dropped;
			out_run_valid_q <= run_valid_d;
			out_job_q       <= run_d;
		end
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.status       = out_status_q;
	assign res_out.dropped      = out_dropped_q;
	assign res_out.run_valid    = out_run_valid_q;
	assign res_out.run_cpu_time = out_job_q.cpu;
	assign res_out.run_io_time  = out_job_q.io;
	assign res_out.run_process  = out_job_q.process;
	assign res_out.run_start    = out_job_q.start;

endmodule
